>>> rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Types and constants for the three-channel sync timer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcst_pkg;

   localparam int NUM_TIMERS      = 3;
   localparam int COUNT_W         = 16;
   localparam int MODE_W          = 10;
   localparam int PULSE_W         = 6;
   localparam int CLOCKS_W        = 6;
   localparam int CSR_INDEX_W     = 3;
   localparam int MAX_TICK_CLOCKS = 63;

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_HSYNC = 2'd1;
   localparam logic [1:0] KIND_VSYNC = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_ZERO = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_ONE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_TWO  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_ZERO   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_ONE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_TWO    = 3'd5;

   // mode register bit positions
   localparam int MODE_SYNC_EN    = 0;
   localparam int MODE_SYNC_LSB   = 1;
   localparam int MODE_RST_TARGET = 3;
   localparam int MODE_IRQ_TARGET = 4;
   localparam int MODE_IRQ_FFFF   = 5;
   localparam int MODE_IRQ_REPEAT = 6;
   localparam int MODE_IRQ_TOGGLE = 7;
   localparam int MODE_CLK_SRC    = 8;
   localparam int MODE_DIVIDER    = 9;

   // sync modes
   localparam logic [1:0] SYNC_PAUSE_LEVEL = 2'd0;
   localparam logic [1:0] SYNC_CLEAR       = 2'd1;
   localparam logic [1:0] SYNC_CLEAR_GATE  = 2'd2;
   localparam logic [1:0] SYNC_RELEASE     = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_SATURATE = 16'hffff;

   typedef struct packed {
      logic [1:0]          kind;
      logic [CLOCKS_W-1:0] clocks;
      logic                line;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    count_zero;
      logic [COUNT_W-1:0]    count_one;
      logic [COUNT_W-1:0]    count_two;
      logic [PULSE_W-1:0]    pulses_zero;
      logic [PULSE_W-1:0]    pulses_one;
      logic [PULSE_W-1:0]    pulses_two;
      logic [NUM_TIMERS-1:0] target_flags;
      logic [NUM_TIMERS-1:0] saturate_flags;
   } rsp_payload_type;

   typedef struct packed {
      logic               level;
      logic               done;
      logic [PULSE_W-1:0] pulses;
   } irq_type;

   typedef struct packed {
      logic clear;
      logic paused;
      logic active;
   } sync_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/three_channel_sync_timer.sv
// ----------------------------------------------------------------------------
// three_channel_sync_timer
// Three 16-bit counters with target / 0xffff compare, sync gating and
// pulse or toggle interrupts, driven by tick and sync requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_data (kind, clocks, line)
//  rsp       out        rsp_valid/rsp_stall  rsp_data (counts, pulses, flags)
//  csr       in         csr_write_en         csr_index, csr_wdata
//
//  One increment-and-compare unit visits timers 0, 1, 2 in turn,
//  one count per cycle.
//  Reset is synchronous; all state but amt_ff and rsp_data_ff returns to idle.
//  req_stall is high while a request is in work; the result register lets
//  the next request start while the previous result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module three_channel_sync_timer
   import tcst_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_wdata
);

   localparam logic [1:0] LAST_TMR = 2'(NUM_TIMERS - 1);

   state_type state_ff, state_in;
   logic [1:0] tmr_ff, tmr_in;

   logic [NUM_TIMERS-1:0][COUNT_W-1:0]  target_ff, target_in;
   logic [NUM_TIMERS-1:0][MODE_W-1:0]   mode_ff, mode_in;
   logic [NUM_TIMERS-1:0][COUNT_W-1:0]  counts_ff, counts_in;
   logic [NUM_TIMERS-1:0][PULSE_W-1:0]  pulses_ff, pulses_in;
   logic [NUM_TIMERS-1:0][CLOCKS_W-1:0] amt_ff, amt_in;
   logic [NUM_TIMERS-1:0] paused_ff, paused_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [NUM_TIMERS-1:0] level_ff, level_in;
   logic [NUM_TIMERS-1:0] done_ff, done_in;
   logic [NUM_TIMERS-1:0] hit_t_ff, hit_t_in;
   logic [NUM_TIMERS-1:0] hit_s_ff, hit_s_in;
   logic [2:0] dot_ff, dot_in;
   logic [2:0] div_ff, div_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // temporaries of the combinational block
   logic [CLOCKS_W-1:0] tick_n;
   logic [CLOCKS_W:0]   dot_sum, div_sum;
   logic [14:0]         dot_prod;
   logic [4:0]          dot_quot;
   logic [CLOCKS_W:0]   dot_rem;
   logic                t2_gate;
   sync_type            sync_v;
   logic [COUNT_W-1:0]  cnt_cur, cnt_next;
   logic [MODE_W-1:0]   mode_cur;
   irq_type             irq_v;
   logic [1:0]          csr_tmr;

   function automatic logic [PULSE_W-1:0] sat_inc(logic [PULSE_W-1:0] p);
      return (p == {PULSE_W{1'b1}}) ? p : p + 1'b1;
   endfunction

   function automatic irq_type raise_irq(irq_type s, logic [MODE_W-1:0] m);
      irq_type r;
      r = s;
      if (!s.done) begin
         if (!m[MODE_IRQ_TOGGLE]) begin
            r.pulses = sat_inc(s.pulses);
         end else begin
            r.level = !s.level;
            // pulse counted on the falling toggle
            if (s.level) r.pulses = sat_inc(s.pulses);
         end
         if (!m[MODE_IRQ_REPEAT]) r.done = 1'b1;
      end
      return r;
   endfunction

   function automatic sync_type sync_event(logic active, logic paused,
                                           logic [1:0] smode, logic line);
      sync_type r;
      r.clear  = 1'b0;
      r.paused = paused;
      r.active = active;
      if (active) begin
         unique case (smode)
            SYNC_PAUSE_LEVEL: r.paused = line;
            SYNC_CLEAR:       r.clear = line;
            SYNC_CLEAR_GATE: begin
               r.clear  = line;
               r.paused = !line;
            end
            SYNC_RELEASE: begin
               if (line) begin
                  r.paused = 1'b0;
                  r.active = 1'b0;
               end
            end
         endcase
      end
      return r;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      tmr_in       = tmr_ff;
      target_in    = target_ff;
      mode_in      = mode_ff;
      counts_in    = counts_ff;
      pulses_in    = pulses_ff;
      amt_in       = amt_ff;
      paused_in    = paused_ff;
      active_in    = active_ff;
      level_in     = level_ff;
      done_in      = done_ff;
      hit_t_in     = hit_t_ff;
      hit_s_in     = hit_s_ff;
      dot_in       = dot_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      tick_n   = (32'(req_data.clocks) > MAX_TICK_CLOCKS) ?
                 CLOCKS_W'(MAX_TICK_CLOCKS) : req_data.clocks;
      dot_sum  = {1'b0, tick_n} + {{(CLOCKS_W-2){1'b0}}, dot_ff};
      div_sum  = {1'b0, tick_n} + {{(CLOCKS_W-2){1'b0}}, div_ff};
      // divide by 5 through the reciprocal 205/1024, exact for these sums
      dot_prod = 15'(dot_sum) * 15'd205;
      dot_quot = dot_prod[14:10];
      dot_rem  = dot_sum - (7'(dot_quot) * 7'd5);
      t2_gate  = !active_ff[2] ||
                 (mode_ff[2][MODE_SYNC_LSB +: 2] == SYNC_CLEAR) ||
                 (mode_ff[2][MODE_SYNC_LSB +: 2] == SYNC_CLEAR_GATE);
      sync_v   = '0;
      cnt_cur  = counts_ff[tmr_ff];
      cnt_next = cnt_cur + 1'b1;
      mode_cur = mode_ff[tmr_ff];
      irq_v    = '{level: level_ff[tmr_ff], done: done_ff[tmr_ff],
                   pulses: pulses_ff[tmr_ff]};
      csr_tmr  = 2'(csr_index - CSR_MODE_ZERO);

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pulses_in = '0;
               amt_in    = '0;
               tmr_in    = '0;
               state_in  = ST_RUN;
               unique case (req_data.kind)
                  KIND_TICK: begin
                     dot_in = dot_rem[2:0];
                     div_in = div_sum[2:0];
                     amt_in[0] = mode_ff[0][MODE_CLK_SRC] ?
                                 CLOCKS_W'(dot_quot) : tick_n;
                     amt_in[1] = mode_ff[1][MODE_CLK_SRC] ? '0 : tick_n;
                     if (t2_gate) begin
                        amt_in[2] = mode_ff[2][MODE_DIVIDER] ?
                                    CLOCKS_W'(div_sum[CLOCKS_W:3]) : tick_n;
                     end
                  end
                  KIND_HSYNC: begin
                     sync_v = sync_event(active_ff[0], paused_ff[0],
                                         mode_ff[0][MODE_SYNC_LSB +: 2],
                                         req_data.line);
                     if (sync_v.clear) counts_in[0] = '0;
                     paused_in[0] = sync_v.paused;
                     active_in[0] = sync_v.active;
                     if (mode_ff[1][MODE_CLK_SRC] && req_data.line) begin
                        amt_in[1] = CLOCKS_W'(1);
                     end
                  end
                  KIND_VSYNC: begin
                     sync_v = sync_event(active_ff[1], paused_ff[1],
                                         mode_ff[1][MODE_SYNC_LSB +: 2],
                                         req_data.line);
                     if (sync_v.clear) counts_in[1] = '0;
                     paused_in[1] = sync_v.paused;
                     active_in[1] = sync_v.active;
                  end
                  default: ;
               endcase
            end
         end

         ST_RUN: begin
            if ((amt_ff[tmr_ff] == '0) || (active_ff[tmr_ff] && paused_ff[tmr_ff])) begin
               if (tmr_ff == LAST_TMR) state_in = ST_DONE;
               else tmr_in = tmr_ff + 1'b1;
            end else begin
               // one increment with both compares
               if (cnt_cur == target_ff[tmr_ff]) begin
                  hit_t_in[tmr_ff] = 1'b1;
                  if (mode_cur[MODE_RST_TARGET]) cnt_next = '0;
                  if (mode_cur[MODE_IRQ_TARGET]) irq_v = raise_irq(irq_v, mode_cur);
               end
               if (cnt_next == COUNT_SATURATE) begin
                  hit_s_in[tmr_ff] = 1'b1;
                  if (!mode_cur[MODE_RST_TARGET]) cnt_next = '0;
                  if (mode_cur[MODE_IRQ_FFFF]) irq_v = raise_irq(irq_v, mode_cur);
               end
               counts_in[tmr_ff] = cnt_next;
               level_in[tmr_ff]  = irq_v.level;
               done_in[tmr_ff]   = irq_v.done;
               pulses_in[tmr_ff] = irq_v.pulses;
               amt_in[tmr_ff]    = amt_ff[tmr_ff] - 1'b1;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{count_zero:     counts_ff[0],
                                count_one:      counts_ff[1],
                                count_two:      counts_ff[2],
                                pulses_zero:    pulses_ff[0],
                                pulses_one:     pulses_ff[1],
                                pulses_two:     pulses_ff[2],
                                target_flags:   hit_t_ff,
                                saturate_flags: hit_s_ff};
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // register writes must arrive only while idle; the block itself does not enforce it
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TARGET_ZERO, CSR_TARGET_ONE, CSR_TARGET_TWO: begin
               target_in[csr_index[1:0]] = csr_wdata;
            end
            CSR_MODE_ZERO, CSR_MODE_ONE, CSR_MODE_TWO: begin
               mode_in[csr_tmr]   = csr_wdata[MODE_W-1:0];
               active_in[csr_tmr] = csr_wdata[MODE_SYNC_EN];
               counts_in[csr_tmr] = '0;
               if (csr_tmr == LAST_TMR) begin
                  paused_in[csr_tmr] =
                     (csr_wdata[MODE_SYNC_LSB +: 2] == SYNC_RELEASE) ||
                     (csr_wdata[MODE_SYNC_LSB +: 2] == SYNC_PAUSE_LEVEL);
               end else begin
                  paused_in[csr_tmr] =
                     (csr_wdata[MODE_SYNC_LSB +: 2] == SYNC_RELEASE);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tmr_ff       <= '0;
         target_ff    <= '0;
         mode_ff      <= '0;
         counts_ff    <= '0;
         pulses_ff    <= '0;
         paused_ff    <= '0;
         active_ff    <= '0;
         level_ff     <= '1;
         done_ff      <= '0;
         hit_t_ff     <= '0;
         hit_s_ff     <= '0;
         dot_ff       <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tmr_ff       <= tmr_in;
         target_ff    <= target_in;
         mode_ff      <= mode_in;
         counts_ff    <= counts_in;
         pulses_ff    <= pulses_in;
         paused_ff    <= paused_in;
         active_ff    <= active_in;
         level_ff     <= level_in;
         done_ff      <= done_in;
         hit_t_ff     <= hit_t_in;
         hit_s_ff     <= hit_s_in;
         dot_ff       <= dot_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amt_ff      <= amt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> tb/tb_three_channel_sync_timer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_channel_sync_timer
// Self-checking bench for the three-channel sync timer. Tick, hsync and vsync
// requests go in over the valid/stall port; a built-in timer model predicts
// each response, which is checked field by field. Directed runs cover the
// sync modes, pulse limits and 0xffff saturation, then random configs run
// under sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------

module tb_three_channel_sync_timer;
   import tcst_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int DRAIN_CYCLES  = 3 * MAX_TICK_CLOCKS + 16;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COUNT_W-1:0]     csr_wdata = '0;

   three_channel_sync_timer DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // timer model state
   logic [COUNT_W-1:0] target_q [NUM_TIMERS];
   logic [MODE_W-1:0]  mode_q   [NUM_TIMERS];
   logic [COUNT_W-1:0] count_q  [NUM_TIMERS];
   bit                 paused   [NUM_TIMERS];
   bit                 sync_on  [NUM_TIMERS];
   bit                 irq_line [NUM_TIMERS];
   bit                 irq_spent[NUM_TIMERS];
   bit                 seen_target[NUM_TIMERS];
   bit                 seen_ffff  [NUM_TIMERS];
   int                 pulse_tally[NUM_TIMERS];
   int                 dot_left;
   int                 div_left;

   rsp_payload_type    expected_reports[$];
   rsp_payload_type    oldest_report;
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;
   int                 send_idle_pct  = 0;
   int                 rsp_stall_pct  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] mode_bit(int pos);
      return 16'(1) << pos;
   endfunction

   function automatic logic [1:0] sync_sel(int t);
      return mode_q[t][MODE_SYNC_LSB +: 2];
   endfunction

   task automatic clear_model();
      for (int t = 0; t < NUM_TIMERS; t++) begin
         target_q[t]    = '0;
         mode_q[t]      = '0;
         count_q[t]     = '0;
         paused[t]      = 1'b0;
         sync_on[t]     = 1'b0;
         irq_line[t]    = 1'b1;
         irq_spent[t]   = 1'b0;
         seen_target[t] = 1'b0;
         seen_ffff[t]   = 1'b0;
         pulse_tally[t] = 0;
      end
      dot_left = 0;
      div_left = 0;
   endtask

   function automatic void fire_irq(int t);
      if (irq_spent[t])
         return;
      if (!mode_q[t][MODE_IRQ_TOGGLE]) begin
         if (pulse_tally[t] < 63) pulse_tally[t]++;
      end else begin
         irq_line[t] = !irq_line[t];
         if (!irq_line[t] && pulse_tally[t] < 63) pulse_tally[t]++;
      end
      if (!mode_q[t][MODE_IRQ_REPEAT])
         irq_spent[t] = 1'b1;
   endfunction

   function automatic void count_up(int t, int steps);
      logic [COUNT_W-1:0] prior;
      if (sync_on[t] && paused[t])
         return;
      repeat (steps) begin
         prior      = count_q[t];
         count_q[t] = count_q[t] + 16'd1;
         if (prior == target_q[t]) begin
            seen_target[t] = 1'b1;
            if (mode_q[t][MODE_RST_TARGET]) count_q[t] = '0;
            if (mode_q[t][MODE_IRQ_TARGET]) fire_irq(t);
         end
         if (count_q[t] == COUNT_SATURATE) begin
            seen_ffff[t] = 1'b1;
            if (!mode_q[t][MODE_RST_TARGET]) count_q[t] = '0;
            if (mode_q[t][MODE_IRQ_FFFF]) fire_irq(t);
         end
      end
   endfunction

   function automatic void apply_line(int t, bit level);
      if (!sync_on[t])
         return;
      case (sync_sel(t))
         SYNC_PAUSE_LEVEL: paused[t] = level;
         SYNC_CLEAR: if (level) count_q[t] = '0;
         SYNC_CLEAR_GATE: begin
            if (level) count_q[t] = '0;
            paused[t] = !level;
         end
         default: if (level) begin
            paused[t]  = 1'b0;
            sync_on[t] = 1'b0;
         end
      endcase
   endfunction

   function automatic rsp_payload_type predict_report(req_payload_type r);
      rsp_payload_type rep;
      int  steps;
      int  dots;
      int  divs;
      bit  gate_two;
      for (int t = 0; t < NUM_TIMERS; t++) pulse_tally[t] = 0;
      gate_two = !sync_on[2] || sync_sel(2) == SYNC_CLEAR || sync_sel(2) == SYNC_CLEAR_GATE;
      case (r.kind)
         KIND_TICK: begin
            steps = r.clocks;
            if (steps > MAX_TICK_CLOCKS) steps = MAX_TICK_CLOCKS;
            dots     = dot_left + steps;
            divs     = div_left + steps;
            dot_left = dots % 5;
            div_left = divs % 8;
            if (!mode_q[0][MODE_CLK_SRC]) count_up(0, steps);
            if (!mode_q[1][MODE_CLK_SRC]) count_up(1, steps);
            if (!mode_q[2][MODE_DIVIDER] && gate_two) count_up(2, steps);
            if (mode_q[0][MODE_CLK_SRC]) count_up(0, dots / 5);
            if (mode_q[2][MODE_DIVIDER] && gate_two) count_up(2, divs / 8);
         end
         KIND_HSYNC: begin
            apply_line(0, r.line);
            if (mode_q[1][MODE_CLK_SRC] && r.line) count_up(1, 1);
         end
         KIND_VSYNC: apply_line(1, r.line);
         default: ;
      endcase
      rep.count_zero  = count_q[0];
      rep.count_one   = count_q[1];
      rep.count_two   = count_q[2];
      rep.pulses_zero = PULSE_W'(pulse_tally[0]);
      rep.pulses_one  = PULSE_W'(pulse_tally[1]);
      rep.pulses_two  = PULSE_W'(pulse_tally[2]);
      for (int t = 0; t < NUM_TIMERS; t++) begin
         rep.target_flags[t]   = seen_target[t];
         rep.saturate_flags[t] = seen_ffff[t];
      end
      return rep;
   endfunction

   task automatic load_mode(int t, logic [COUNT_W-1:0] value);
      mode_q[t]  = value[MODE_W-1:0];
      sync_on[t] = value[MODE_SYNC_EN];
      count_q[t] = '0;
      if (t == 2)
         paused[t] = sync_sel(t) == SYNC_RELEASE || sync_sel(t) == SYNC_PAUSE_LEVEL;
      else
         paused[t] = sync_sel(t) == SYNC_RELEASE;
   endtask

   task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // scoreboard: check the response first, then log any newly accepted request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               oldest_report = expected_reports.pop_front();
               check_field("count_zero", oldest_report.count_zero, rsp_data.count_zero);
               check_field("count_one", oldest_report.count_one, rsp_data.count_one);
               check_field("count_two", oldest_report.count_two, rsp_data.count_two);
               check_field("pulses_zero", oldest_report.pulses_zero, rsp_data.pulses_zero);
               check_field("pulses_one", oldest_report.pulses_one, rsp_data.pulses_one);
               check_field("pulses_two", oldest_report.pulses_two, rsp_data.pulses_two);
               check_field("target_flags", oldest_report.target_flags,
                           rsp_data.target_flags);
               check_field("saturate_flags", oldest_report.saturate_flags,
                           rsp_data.saturate_flags);
            end
         end
         if (req_valid && !req_stall)
            expected_reports.push_back(predict_report(req_data));
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // all tasks below start and end just after a falling edge;
   // a register write stays enabled until the next request or idle wait
   task automatic send_request(logic [1:0] kind, logic [CLOCKS_W-1:0] clocks, logic line);
      int gap;
      csr_write_en <= 1'b0;
      req_data  <= '{kind: kind, clocks: clocks, line: line};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid    <= 1'b0;
      csr_write_en <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [COUNT_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      case (index)
         CSR_TARGET_ZERO: target_q[0] = value;
         CSR_TARGET_ONE:  target_q[1] = value;
         CSR_TARGET_TWO:  target_q[2] = value;
         CSR_MODE_ZERO:   load_mode(0, value);
         CSR_MODE_ONE:    load_mode(1, value);
         CSR_MODE_TWO:    load_mode(2, value);
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [COUNT_W-1:0] pick_target();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COUNT_SATURATE;
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(1, 150));
      endcase
   endfunction

   task automatic test_reset_state();
      send_request(KIND_TICK, '0, 1'b0);
      send_request(KIND_TICK, CLOCKS_W'(MAX_TICK_CLOCKS), 1'b1);
      send_request(KIND_HSYNC, 6'd5, 1'b1);
      send_request(KIND_UNUSED, CLOCKS_W'(MAX_TICK_CLOCKS), 1'b1);
   endtask

   task automatic test_sync_modes();
      wait_idle();
      write_register(CSR_TARGET_ZERO, 16'd10);
      write_register(CSR_TARGET_ONE, 16'd3);
      write_register(CSR_TARGET_TWO, COUNT_SATURATE);
      write_register(CSR_SPARE_LO, 16'hffff);
      write_register(CSR_SPARE_HI, 16'h1234);
      for (int m = 0; m < 4; m++) begin
         wait_idle();
         write_register(CSR_MODE_ZERO, mode_bit(MODE_SYNC_EN) | (16'(m) << MODE_SYNC_LSB) |
                        mode_bit(MODE_IRQ_TARGET) | mode_bit(MODE_IRQ_REPEAT));
         write_register(CSR_MODE_ONE, mode_bit(MODE_SYNC_EN) | (16'(m) << MODE_SYNC_LSB) |
                        mode_bit(MODE_CLK_SRC) | mode_bit(MODE_RST_TARGET) |
                        mode_bit(MODE_IRQ_TARGET) | mode_bit(MODE_IRQ_TOGGLE) |
                        mode_bit(MODE_IRQ_REPEAT));
         write_register(CSR_MODE_TWO, mode_bit(MODE_SYNC_EN) | (16'(m) << MODE_SYNC_LSB) |
                        mode_bit(MODE_DIVIDER));
         send_request(KIND_HSYNC, 6'd0, 1'b1);
         send_request(KIND_VSYNC, 6'd63, 1'b1);
         send_request(KIND_TICK, 6'd17, 1'b0);
         send_request(KIND_HSYNC, 6'd42, 1'b0);
         send_request(KIND_VSYNC, 6'd21, 1'b0);
         send_request(KIND_TICK, 6'd9, 1'b1);
      end
   endtask

   task automatic test_pulse_limits();
      wait_idle();
      write_register(CSR_TARGET_ZERO, '0);
      write_register(CSR_TARGET_ONE, '0);
      write_register(CSR_TARGET_TWO, '0);
      // target 0 with reset-at-target fires on every clock: 63 pulses per tick
      write_register(CSR_MODE_ZERO, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET) |
                     mode_bit(MODE_IRQ_REPEAT));
      write_register(CSR_MODE_ONE, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET) |
                     mode_bit(MODE_IRQ_REPEAT));
      write_register(CSR_MODE_TWO, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET) |
                     mode_bit(MODE_IRQ_REPEAT));
      send_request(KIND_TICK, CLOCKS_W'(MAX_TICK_CLOCKS), 1'b0);
      wait_idle();
      write_register(CSR_MODE_ZERO, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET) |
                     mode_bit(MODE_IRQ_TOGGLE));
      write_register(CSR_MODE_ONE, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET) |
                     mode_bit(MODE_IRQ_TOGGLE) | mode_bit(MODE_IRQ_REPEAT));
      write_register(CSR_MODE_TWO, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET));
      send_request(KIND_TICK, CLOCKS_W'(MAX_TICK_CLOCKS), 1'b1);
      wait_idle();
      write_register(CSR_TARGET_ZERO, COUNT_SATURATE);
      write_register(CSR_TARGET_ONE, COUNT_SATURATE);
      write_register(CSR_TARGET_TWO, COUNT_SATURATE);
      write_register(CSR_MODE_ZERO, 16'h03ff);
      write_register(CSR_MODE_ONE, 16'h03ff);
      write_register(CSR_MODE_TWO, 16'h03ff);
      send_request(KIND_TICK, CLOCKS_W'(MAX_TICK_CLOCKS), 1'b0);
      send_request(KIND_HSYNC, 6'd1, 1'b1);
   endtask

   // run counters 0 and 1 to 0xffff and counter 2 to its 0xfffe target with full-length ticks
   task automatic test_saturation();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_idle();
      write_register(CSR_TARGET_ZERO, 16'h8000);
      write_register(CSR_TARGET_ONE, COUNT_SATURATE);
      write_register(CSR_TARGET_TWO, 16'hfffe);
      write_register(CSR_MODE_ZERO, mode_bit(MODE_IRQ_FFFF) | mode_bit(MODE_IRQ_REPEAT));
      write_register(CSR_MODE_ONE, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET) |
                     mode_bit(MODE_IRQ_FFFF) | mode_bit(MODE_IRQ_TOGGLE) |
                     mode_bit(MODE_IRQ_REPEAT));
      write_register(CSR_MODE_TWO, mode_bit(MODE_RST_TARGET) | mode_bit(MODE_IRQ_TARGET));
      repeat (1050) send_request(KIND_TICK, CLOCKS_W'(MAX_TICK_CLOCKS), 1'b0);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int segments, int per_seg);
      logic [1:0]          kind;
      logic [CLOCKS_W-1:0] clocks;
      for (int s = 0; s < segments; s++) begin
         wait_idle();
         write_register(CSR_TARGET_ZERO, pick_target());
         write_register(CSR_TARGET_ONE, pick_target());
         write_register(CSR_TARGET_TWO, pick_target());
         write_register(CSR_MODE_ZERO, 16'($urandom_range(0, 1023)));
         write_register(CSR_MODE_ONE, 16'($urandom_range(0, 1023)));
         write_register(CSR_MODE_TWO, 16'($urandom_range(0, 1023)));
         // some segments run without any idling
         send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
         rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : stall_pct;
         repeat (per_seg) begin
            case ($urandom_range(0, 19))
               0:          kind = KIND_UNUSED;
               1, 2, 3, 4: kind = KIND_HSYNC;
               5, 6, 7:    kind = KIND_VSYNC;
               default:    kind = KIND_TICK;
            endcase
            case ($urandom_range(0, 7))
               0:       clocks = '0;
               1:       clocks = CLOCKS_W'(MAX_TICK_CLOCKS);
               default: clocks = CLOCKS_W'($urandom_range(0, 63));
            endcase
            send_request(kind, clocks, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      clear_model();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_sync_modes();
      test_pulse_limits();
      test_saturation();
      test_random_traffic(0, 0, 4, 45);
      test_random_traffic(61, 0, 4, 45);
      test_random_traffic(0, 61, 4, 45);
      test_random_traffic(38, 38, 4, 45);
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
